>>> hdl/mva_pkg.sv
// Shared types and constants for the moving window average block.
// Used by mva_div, mva_dp, mva_ctrl and moving_window_average_top.
`timescale 1ns / 1ps
`default_nettype none

package mva_pkg;

  localparam int WS_W       = 7;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic            REG_WINDOW_SIZE = 1'b0;
  localparam logic [WS_W-1:0] WS_RESET        = 7'd1;

  typedef struct packed {
    logic rd;
    logic upd;
    logic start;
    logic out_load;
  } mva_cmd_t;

endpackage

`default_nettype wire

>>> hdl/moving_window_average_top.sv
// Top level of the moving window average (boxcar) filter.
// Depends on mva_pkg, mva_ctrl, mva_dp (with mva_div).
//
//  Port group  Dir  Contents
//  in_*        in   stream, tdata = sample
//  out_*       out  stream, tdata = average, tuser = window_full
//  cfg_*       in   APB, register 0 at 0x0 = window_size
//
// A result is offered once its item has passed the read, update, start, divide
// and done states; a new item is taken only after the one-bit-a-cycle divider
// has finished and the result has been loaded into the output register.
// in_tready is high only while idle. A finished result waits in the output
// register; the next item is taken meanwhile. rst_n is synchronous; the ring
// memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module moving_window_average_top #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  in_tdata,   // sample
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       out_tdata,  // average
  output logic                                    out_tuser,  // window_full
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [mva_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [mva_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [mva_pkg::CFG_DATA_W-1:0]          cfg_prdata,
  output logic                                    cfg_pready
);

  localparam int TD_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int WS_W = mva_pkg::WS_W;

  logic [WS_W-1:0]         ws_r, ws_nxt;
  logic                    cfg_wr;
  logic [WS_W-1:0]         wr_val;
  mva_pkg::mva_cmd_t       cmd;
  logic                    div_done;
  logic [SAMPLE_WIDTH-1:0] avg;
  logic                    full;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == mva_pkg::REG_WINDOW_SIZE);
  assign wr_val     = cfg_pwdata[WS_W-1:0];

  always_comb begin
    if (wr_val == '0) begin
      ws_nxt = WS_W'(1);
    end else if (int'(wr_val) > WINDOW_MAX) begin
      ws_nxt = WS_W'(WINDOW_MAX);
    end else begin
      ws_nxt = wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= mva_pkg::WS_RESET;
    end else if (cfg_wr) begin
      ws_r <= ws_nxt;
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      mva_pkg::REG_WINDOW_SIZE: cfg_prdata = mva_pkg::CFG_DATA_W'(ws_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  mva_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .div_done   (div_done),
    .cmd        (cmd)
  );

  mva_dp #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .clr         (cfg_wr),
    .win_size    (ws_r),
    .in_sample   (in_tdata[SAMPLE_WIDTH-1:0]),
    .div_done    (div_done),
    .out_average (avg),
    .out_full    (full)
  );

  assign out_tdata = TD_W'(avg);
  assign out_tuser = full;

endmodule

`default_nettype wire

>>> hdl/mva_div.sv
// Iterative restoring divider: signed sum over unsigned count, one bit a cycle.
// Depends on mva_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mva_div #(
  parameter int SUM_W = 22,
  parameter int SW    = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [SUM_W-1:0]  dividend,
  input  wire logic [mva_pkg::WS_W-1:0] divisor,
  output logic signed [SW-1:0]          quotient,
  output logic                          done
);

  localparam int RW    = mva_pkg::WS_W;
  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [RW-1:0]    dvs_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [RW:0]      rem_sh;
  logic [RW:0]      diff;
  logic [SUM_W-1:0] mag;
  logic [SUM_W-1:0] res;

  assign mag = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;

  always_comb begin
    rem_sh = {rem_r, quo_r[SUM_W-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    if (!diff[RW]) begin
      rem_nxt = diff[RW-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[RW-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= mag;
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= dividend[SUM_W-1];
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign res      = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient = res[SW-1:0];
  assign done     = done_r;

endmodule

`default_nettype wire

>>> hdl/mva_dp.sv
// Datapath: sample ring memory, running sum, held count, pointer, divider, result.
// Depends on mva_pkg and mva_div.
`timescale 1ns / 1ps
`default_nettype none

module mva_dp #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire mva_pkg::mva_cmd_t          cmd,
  input  wire logic                       clr,
  input  wire logic [mva_pkg::WS_W-1:0]   win_size,
  input  wire logic [SAMPLE_WIDTH-1:0]    in_sample,
  output logic                            div_done,
  output logic [SAMPLE_WIDTH-1:0]         out_average,
  output logic                            out_full
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int WS_W  = mva_pkg::WS_W;
  localparam int PW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W = SW + PW;
  localparam int CMP_W = (PW + 1 > WS_W) ? PW + 1 : WS_W;

  logic [SW-1:0]           hist_mem [WINDOW_MAX];
  logic [SW-1:0]           old_r;
  logic [SW-1:0]           sample_r;
  logic [PW-1:0]           ptr_r, ptr_nxt;
  logic [WS_W-1:0]         count_r, count_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    full_r;
  logic [SW-1:0]           avg_r;
  logic                    avg_full_r;
  logic signed [SUM_W-1:0] s_ext, old_ext;
  logic [CMP_W-1:0]        ptr_inc;
  logic                    was_full;
  logic signed [SW-1:0]    quo;

  assign s_ext    = SUM_W'(signed'(sample_r));
  assign old_ext  = SUM_W'(signed'(old_r));
  assign was_full = (count_r >= win_size);
  assign ptr_inc  = CMP_W'(ptr_r) + 1'b1;

  always_comb begin
    if (was_full) begin
      sum_nxt   = sum_r - old_ext + s_ext;
      count_nxt = win_size;
    end else begin
      sum_nxt   = sum_r + s_ext;
      count_nxt = count_r + 1'b1;
    end
    if (ptr_inc >= CMP_W'(win_size)) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = ptr_inc[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      old_r <= hist_mem[ptr_r];
    end
    if (cmd.upd) begin
      hist_mem[ptr_r] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      count_r <= '0;
      sum_r   <= '0;
      full_r  <= 1'b0;
    end else if (clr) begin
      ptr_r   <= '0;
      count_r <= '0;
      sum_r   <= '0;
      full_r  <= 1'b0;
    end else if (cmd.upd) begin
      ptr_r   <= ptr_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      full_r  <= (count_nxt == win_size);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      sample_r <= in_sample;
    end
    if (cmd.out_load) begin
      avg_r      <= quo;
      avg_full_r <= full_r;
    end
  end

  mva_div #(
    .SUM_W (SUM_W),
    .SW    (SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start),
    .dividend (sum_r),
    .divisor  (count_r),
    .quotient (quo),
    .done     (div_done)
  );

  assign out_average = avg_r;
  assign out_full    = avg_full_r;

`ifndef SYNTH
  a_count_le_win: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= win_size)
    else $error("held count above window size");
  a_ptr_lt_win: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(ptr_r) < CMP_W'(win_size))
    else $error("write pointer outside window");
  a_count_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd && !clr |=> count_r != '0)
    else $error("empty window after update");
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    full_r == (count_r == win_size))
    else $error("full flag out of step with count");
`endif

endmodule

`default_nettype wire

>>> hdl/mva_ctrl.sv
// Controller state machine: sequences read, update, divide and result load.
// Depends on mva_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mva_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire logic          div_done,
  output mva_pkg::mva_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.rd    = 1'b1;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_START;
      end
      ST_START: begin
        cmd.start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_tready))
    else $error("result overwritten while stalled");
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside divide state");
  a_start_follows_upd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> $past(cmd.upd))
    else $error("divide started without update");
`endif

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for moving_window_average_top: streams samples, predicts each
// window average and full flag, and checks results. Depends on mva_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int SAMPLE_W    = 16;
  localparam int TDATA_W     = ((SAMPLE_W + 7) / 8) * 8;
  localparam int WIN_MAX     = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  localparam logic [mva_pkg::CFG_ADDR_W-1:0] ADDR_WINDOW_SIZE =
    mva_pkg::CFG_ADDR_W'({mva_pkg::REG_WINDOW_SIZE, 2'b00});
  localparam logic [mva_pkg::CFG_ADDR_W-1:0] ADDR_UNMAPPED    = mva_pkg::CFG_ADDR_W'(4);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum {MIX_ANY, MIX_HIGH, MIX_LOW} sample_mix_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] average;
    logic                       window_full;
  } average_t;

  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           in_tvalid   = 1'b0;
  logic                           in_tready;
  logic [TDATA_W-1:0]             in_tdata    = '0;  // sample
  logic                           out_tvalid;
  logic                           out_tready  = 1'b0;
  logic [TDATA_W-1:0]             out_tdata;         // average
  logic                           out_tuser;         // window_full
  logic                           cfg_psel    = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite  = 1'b0;
  logic [mva_pkg::CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [mva_pkg::CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [mva_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  moving_window_average_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // filter state as seen from outside
  logic signed [SAMPLE_W-1:0] ring_mem [WIN_MAX];
  int ring_wptr  = 0;
  int ring_count = 0;
  int ring_sum   = 0;
  int win_len    = 1;

  average_t pending_averages [$];
  int       mismatches  = 0;
  bit       tx_gaps_on  = 1'b1;
  bit       rx_gaps_on  = 1'b1;
  bit       tx_open     = 1'b0;
  int       rx_hold_req = 0;
  int       idle_cycles = 0;

  function automatic void predict_average(logic signed [SAMPLE_W-1:0] s);
    average_t r;
    int slot;
    slot = ring_wptr % WIN_MAX;
    if (ring_count >= win_len) begin
      ring_sum -= ring_mem[slot];
      ring_count = win_len;
    end else begin
      ring_count++;
    end
    ring_sum += s;
    ring_mem[slot] = s;
    ring_wptr = slot + 1;
    if (ring_wptr >= win_len) ring_wptr = 0;
    r.average     = SAMPLE_W'(ring_sum / ring_count);
    r.window_full = (ring_count == win_len);
    pending_averages.push_back(r);
  endfunction

  function automatic void apply_window_write(logic [mva_pkg::CFG_ADDR_W-1:0] addr,
                                             logic [mva_pkg::CFG_DATA_W-1:0] data);
    int v;
    if (addr != ADDR_WINDOW_SIZE) return;
    v = data[mva_pkg::WS_W-1:0];
    if (v < 1) v = 1;
    if (v > WIN_MAX) v = WIN_MAX;
    win_len    = v;
    ring_wptr  = 0;
    ring_count = 0;
    ring_sum   = 0;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(sample_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_HIGH: return (r < 90) ? SAMPLE_MAX : SAMPLE_W'($urandom);
      MIX_LOW:  return (r < 90) ? SAMPLE_MIN : SAMPLE_W'($urandom);
      default: begin
        if (r < 10) return SAMPLE_MAX;
        if (r < 20) return SAMPLE_MIN;
        if (r < 35) return SAMPLE_W'($urandom_range(0, 16) - 8);
        return SAMPLE_W'($urandom);
      end
    endcase
  endfunction

  task automatic stop_tx();
    if (tx_open) begin
      in_tvalid <= 1'b0;
      tx_open = 1'b0;
    end
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      stop_tx();
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'(s);
    tx_open = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_average(s);
  endtask

  task automatic wait_drain();
    stop_tx();
    while (pending_averages.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [mva_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [mva_pkg::CFG_DATA_W-1:0] data);
    wait_drain();
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    apply_window_write(addr, data);
  endtask

  task automatic check_window_size();
    logic [mva_pkg::CFG_DATA_W-1:0] rd;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_WINDOW_SIZE;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== mva_pkg::CFG_DATA_W'(win_len)) begin
      $error("window_size: expected %0d, got %0d", win_len, rd);
      mismatches++;
    end
  endtask

  task automatic program_window(input logic [mva_pkg::WS_W-1:0] value);
    cfg_write(ADDR_WINDOW_SIZE, mva_pkg::CFG_DATA_W'(value));
    check_window_size();
  endtask

  // result checker and receiver idling
  always @(posedge clk) begin : result_check
    average_t want;
    int rx_gap;
    int rx_hold;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap  = 0;
      rx_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_averages.size() == 0) begin
          $error("unexpected item: average %0d window_full %0b",
                 $signed(out_tdata[SAMPLE_W-1:0]), out_tuser);
          mismatches++;
        end else begin
          want = pending_averages.pop_front();
          if (out_tdata[SAMPLE_W-1:0] !== want.average) begin
            $error("average: expected %0d, got %0d", want.average,
                   $signed(out_tdata[SAMPLE_W-1:0]));
            mismatches++;
          end
          if (out_tuser !== want.window_full) begin
            $error("window_full: expected %0b, got %0b", want.window_full, out_tuser);
            mismatches++;
          end
        end
        rx_gap = rx_gaps_on ? $urandom_range(0, 6) : 0;
      end
      if (rx_hold_req > 0) begin
        rx_hold = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("moving_window_average_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_default_window();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    wait_drain();
  endtask

  task automatic test_window_saturation();
    program_window(7'd0);
    send_sample(SAMPLE_MAX);
    send_sample(-16'sd1);
    program_window(7'd127);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(16'sd100);
    wait_drain();
  endtask

  // a write to an unmapped address must neither change the size nor clear
  task automatic test_unmapped_register();
    program_window(7'd3);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    cfg_write(ADDR_UNMAPPED, mva_pkg::CFG_DATA_W'(50));
    check_window_size();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'sd1);
    wait_drain();
  endtask

  task automatic test_random_windows();
    logic [mva_pkg::WS_W-1:0] w;
    int n;
    program_window(7'(WIN_MAX));
    repeat (WIN_MAX) send_sample(SAMPLE_MAX);
    repeat (WIN_MAX) send_sample(SAMPLE_MIN);
    repeat (20) send_sample(draw_sample(MIX_HIGH));
    repeat (20) send_sample(draw_sample(MIX_ANY));
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       w = 7'd1;
        1:       w = 7'd2;
        2:       w = 7'(WIN_MAX - 1);
        default: w = mva_pkg::WS_W'($urandom_range(0, 127));
      endcase
      program_window(w);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(15, 30);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 5))
          0:       send_sample(draw_sample(MIX_HIGH));
          1:       send_sample(draw_sample(MIX_LOW));
          default: send_sample(draw_sample(MIX_ANY));
        endcase
      end
    end
    wait_drain();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // receiver holds off while items keep coming, so the block backs up
  task automatic test_output_backpressure();
    program_window(7'd5);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    repeat (24) send_sample(draw_sample(MIX_ANY));
    wait_drain();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    repeat (16) send_sample(draw_sample(MIX_ANY));
    wait_drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_default_window();
    test_window_saturation();
    test_unmapped_register();
    test_random_windows();
    test_output_backpressure();
    wait_drain();
    repeat (40) @(posedge clk);
    if (pending_averages.size() != 0) begin
      $error("%0d results never arrived", pending_averages.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("moving_window_average_top test passed");
    end else begin
      $display("moving_window_average_top test failed");
    end
    $finish;
  end

endmodule
